@@ rtl/core/sexp_pkg.sv @@
// Shared types, character codes and token classes for the s-expression tokenizer.
// No dependencies; imported by sexp_lexer and s_expression_tokenizer_core.
package sexp_pkg;

  // Token length saturates at the smaller of this limit and 255
  localparam int         MAX_TOKEN_LEN = 255;
  localparam logic [7:0] LEN_CAP       = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

  // Most results one source byte can cause
  localparam int RES_MAX = 3;

  // Result queue depth, a power of two, and the widths that follow from it
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_BTICK   = 8'h60;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  // Token classes
  localparam logic [3:0] CLS_LPAREN = 4'd0;
  localparam logic [3:0] CLS_RPAREN = 4'd1;
  localparam logic [3:0] CLS_LBRACK = 4'd2;
  localparam logic [3:0] CLS_RBRACK = 4'd3;
  localparam logic [3:0] CLS_LBRACE = 4'd4;
  localparam logic [3:0] CLS_RBRACE = 4'd5;
  localparam logic [3:0] CLS_QUOTE  = 4'd6;
  localparam logic [3:0] CLS_QUASI  = 4'd7;
  localparam logic [3:0] CLS_META   = 4'd8;
  localparam logic [3:0] CLS_TILDE  = 4'd9;
  localparam logic [3:0] CLS_SPLICE = 4'd10;
  localparam logic [3:0] CLS_STRING = 4'd11;
  localparam logic [3:0] CLS_INT    = 4'd12;
  localparam logic [3:0] CLS_SYMBOL = 4'd13;

  // Lexer modes
  typedef enum logic [2:0] {
    M_IDLE,
    M_COMMENT,
    M_TILDE,
    M_STRING,
    M_ESCAPE,
    M_INTEGER,
    M_SYMBOL
  } lex_mode_t;

  // One result item
  typedef struct packed {
    logic        is_text;
    logic [7:0]  text_char;
    logic        token_done;
    logic [3:0]  token_class;
    logic [7:0]  token_length;
    logic [31:0] int_value;
    logic        bad_integer;
    logic        bad_escape;
    logic        unterminated;
    logic        last;
  } result_t;

  // Results of one source byte, in order, n of them valid
  typedef struct packed {
    logic [1:0]                n;
    result_t [RES_MAX-1:0]     res;
  } step_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_NEWLINE, CH_COMMA, CH_TAB, CH_CR};
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c inside {CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                     CH_RBRACE, CH_APOS, CH_BTICK, CH_CARET, CH_TILDE};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [3:0] special_class(input logic [7:0] c);
    logic [3:0] cls;
    case (c)
      CH_LPAREN: cls = CLS_LPAREN;
      CH_RPAREN: cls = CLS_RPAREN;
      CH_LBRACK: cls = CLS_LBRACK;
      CH_RBRACK: cls = CLS_RBRACK;
      CH_LBRACE: cls = CLS_LBRACE;
      CH_RBRACE: cls = CLS_RBRACE;
      CH_APOS:   cls = CLS_QUOTE;
      CH_BTICK:  cls = CLS_QUASI;
      CH_CARET:  cls = CLS_META;
      default:   cls = CLS_TILDE;
    endcase
    return cls;
  endfunction

  function automatic result_t mk_text(input logic [7:0] ch);
    result_t r;
    r           = '0;
    r.is_text   = 1'b1;
    r.text_char = ch;
    return r;
  endfunction

  function automatic result_t mk_sum(input logic [3:0] cls, input logic [7:0] len,
                                     input logic [31:0] val, input logic bi,
                                     input logic be, input logic un);
    result_t r;
    r              = '0;
    r.token_done   = 1'b1;
    r.token_class  = cls;
    r.token_length = len;
    r.int_value    = val;
    r.bad_integer  = bi;
    r.bad_escape   = be;
    r.unterminated = un;
    return r;
  endfunction

endpackage

@@ rtl/core/sexp_lexer.sv @@
// Lexer state and the single-step logic that turns one source byte into up to
// three ordered results. Depends on sexp_pkg.
module sexp_lexer import sexp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] source_char,
  input  logic       end_of_text,
  output step_t      step
);

  lex_mode_t   mode, mode_next;
  logic [7:0]  token_count, token_count_next;
  logic [31:0] accumulator, accumulator_next;
  logic        minus_seen, minus_seen_next;
  logic        digit_fault, digit_fault_next;
  logic        escape_fault, escape_fault_next;

  logic        flush;
  logic        term;
  logic [7:0]  count_bump;
  logic [31:0] acc_step;
  result_t     atom_sum;

  // Effect of starting a new token at this byte
  lex_mode_t   beg_mode;
  logic [7:0]  beg_count;
  logic [31:0] beg_acc;
  logic        beg_minus;
  logic [1:0]  beg_n;
  result_t     beg_r0, beg_r1;

  result_t [RES_MAX-1:0] res;
  logic [1:0]            n;

  assign flush      = end_of_text || (source_char == CH_NUL);
  assign term       = is_space(source_char) || is_special(source_char);
  assign count_bump = (token_count < LEN_CAP) ? token_count + 8'd1 : token_count;
  assign acc_step   = {accumulator[28:0], 3'b000} + {accumulator[30:0], 1'b0}
                    + {28'd0, source_char[3:0]};

  // Close an integer or symbol
  always_comb begin
    if (mode == M_INTEGER) begin
      atom_sum = mk_sum(CLS_INT, token_count,
                        minus_seen ? (32'd0 - accumulator) : accumulator,
                        digit_fault, 1'b0, 1'b0);
    end else begin
      atom_sum = mk_sum(CLS_SYMBOL, token_count, 32'd0, 1'b0, 1'b0, 1'b0);
    end
  end

  // Decode the start of a token
  always_comb begin
    beg_mode  = M_IDLE;
    beg_count = 8'd0;
    beg_acc   = 32'd0;
    beg_minus = 1'b0;
    beg_n     = 2'd0;
    beg_r0    = mk_text(source_char);
    beg_r1    = mk_sum(special_class(source_char), 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
    if (is_space(source_char)) begin
      beg_n = 2'd0;
    end else if (source_char == CH_SEMI) begin
      beg_mode = M_COMMENT;
    end else if (source_char == CH_TILDE) begin
      beg_mode  = M_TILDE;
      beg_count = 8'd1;
      beg_n     = 2'd1;
    end else if (is_special(source_char)) begin
      beg_n = 2'd2;
    end else if (source_char == CH_QUOTE) begin
      beg_mode  = M_STRING;
      beg_count = 8'd1;
    end else if (source_char == CH_MINUS) begin
      beg_mode  = M_INTEGER;
      beg_count = 8'd1;
      beg_minus = 1'b1;
      beg_n     = 2'd1;
    end else if (is_digit(source_char)) begin
      beg_mode  = M_INTEGER;
      beg_count = 8'd1;
      beg_acc   = {28'd0, source_char[3:0]};
      beg_n     = 2'd1;
    end else begin
      beg_mode  = M_SYMBOL;
      beg_count = 8'd1;
      beg_n     = 2'd1;
    end
  end

  // Next state
  always_comb begin
    mode_next         = mode;
    token_count_next  = token_count;
    accumulator_next  = accumulator;
    minus_seen_next   = minus_seen;
    digit_fault_next  = digit_fault;
    escape_fault_next = escape_fault;
    if (flush) begin
      mode_next         = M_IDLE;
      token_count_next  = 8'd0;
      accumulator_next  = 32'd0;
      minus_seen_next   = 1'b0;
      digit_fault_next  = 1'b0;
      escape_fault_next = 1'b0;
    end else begin
      case (mode)
        M_COMMENT: begin
          if (source_char == CH_NEWLINE) mode_next = M_IDLE;
        end
        M_TILDE: begin
          mode_next         = beg_mode;
          token_count_next  = beg_count;
          accumulator_next  = beg_acc;
          minus_seen_next   = beg_minus;
          digit_fault_next  = 1'b0;
          escape_fault_next = 1'b0;
          if (source_char == CH_AT) begin
            mode_next        = M_IDLE;
            token_count_next = 8'd0;
            accumulator_next = 32'd0;
            minus_seen_next  = 1'b0;
          end
        end
        M_STRING: begin
          token_count_next = count_bump;
          if (source_char == CH_QUOTE) begin
            mode_next         = M_IDLE;
            token_count_next  = 8'd0;
            escape_fault_next = 1'b0;
          end else if (source_char == CH_BSLASH) begin
            mode_next = M_ESCAPE;
          end
        end
        M_ESCAPE: begin
          token_count_next = count_bump;
          mode_next        = M_STRING;
          if (!(source_char inside {CH_QUOTE, CH_BSLASH, CH_N})) escape_fault_next = 1'b1;
        end
        M_INTEGER, M_SYMBOL: begin
          if (term) begin
            mode_next         = beg_mode;
            token_count_next  = beg_count;
            accumulator_next  = beg_acc;
            minus_seen_next   = beg_minus;
            digit_fault_next  = 1'b0;
            escape_fault_next = 1'b0;
          end else begin
            token_count_next = count_bump;
            if (mode == M_INTEGER && !digit_fault) begin
              if (is_digit(source_char)) accumulator_next = acc_step;
              else                       digit_fault_next = 1'b1;
            end
          end
        end
        default: begin
          mode_next         = beg_mode;
          token_count_next  = beg_count;
          accumulator_next  = beg_acc;
          minus_seen_next   = beg_minus;
          digit_fault_next  = 1'b0;
          escape_fault_next = 1'b0;
        end
      endcase
    end
  end

  // Results of this byte
  always_comb begin
    res = '0;
    n   = 2'd0;
    if (flush) begin
      case (mode)
        M_TILDE: begin
          res[0] = mk_sum(CLS_TILDE, 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
          n      = 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          res[0] = mk_sum(CLS_STRING, token_count, 32'd0, 1'b0, escape_fault, 1'b1);
          n      = 2'd1;
        end
        M_INTEGER, M_SYMBOL: begin
          res[0] = atom_sum;
          n      = 2'd1;
        end
        default: n = 2'd0;
      endcase
    end else begin
      case (mode)
        M_COMMENT: n = 2'd0;
        M_TILDE: begin
          if (source_char == CH_AT) begin
            res[0] = mk_text(source_char);
            res[1] = mk_sum(CLS_SPLICE, 8'd2, 32'd0, 1'b0, 1'b0, 1'b0);
            n      = 2'd2;
          end else begin
            res[0] = mk_sum(CLS_TILDE, 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
            res[1] = beg_r0;
            res[2] = beg_r1;
            n      = 2'd1 + beg_n;
          end
        end
        M_STRING: begin
          if (source_char == CH_QUOTE) begin
            res[0] = mk_sum(CLS_STRING, count_bump, 32'd0, 1'b0, escape_fault, 1'b0);
            n      = 2'd1;
          end else if (source_char != CH_BSLASH) begin
            res[0] = mk_text(source_char);
            n      = 2'd1;
          end
        end
        M_ESCAPE: begin
          if (source_char == CH_QUOTE || source_char == CH_BSLASH) begin
            res[0] = mk_text(source_char);
            n      = 2'd1;
          end else if (source_char == CH_N) begin
            res[0] = mk_text(CH_NEWLINE);
            n      = 2'd1;
          end
        end
        M_INTEGER, M_SYMBOL: begin
          if (term) begin
            res[0] = atom_sum;
            res[1] = beg_r0;
            res[2] = beg_r1;
            n      = 2'd1 + beg_n;
          end else begin
            res[0] = mk_text(source_char);
            n      = 2'd1;
          end
        end
        default: begin
          res[0] = beg_r0;
          res[1] = beg_r1;
          n      = beg_n;
        end
      endcase
    end
    // Mark the final result of the byte
    for (int i = 0; i < RES_MAX; i++) begin
      res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  assign step.n   = n;
  assign step.res = res;

  // Advance the lexer on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      token_count  <= 8'd0;
      accumulator  <= 32'd0;
      minus_seen   <= 1'b0;
      digit_fault  <= 1'b0;
      escape_fault <= 1'b0;
    end else if (take) begin
      mode         <= mode_next;
      token_count  <= token_count_next;
      accumulator  <= accumulator_next;
      minus_seen   <= minus_seen_next;
      digit_fault  <= digit_fault_next;
      escape_fault <= escape_fault_next;
    end
  end

endmodule

@@ rtl/core/s_expression_tokenizer_core.sv @@
// Each source byte goes through the lexer step, which writes its zero to three results
// into a four-entry result queue that drains one result per cycle while res_stall is
// low. The source side stalls while two or more results are queued, so bytes that give
// at most one result flow at one per cycle while the result side does not stall; a byte
// giving two or three results holds the source until fewer than two results are queued.
// Top level of the s-expression tokenizer. Depends on sexp_pkg and sexp_lexer.
module s_expression_tokenizer_core import sexp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic [7:0]         source_char,
  input  logic               end_of_text,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               is_text,
  output logic [7:0]         text_char,
  output logic               token_done,
  output logic [3:0]         token_class,
  output logic [7:0]         token_length,
  output logic signed [31:0] int_value,
  output logic               bad_integer,
  output logic               bad_escape,
  output logic               unterminated,
  output logic               last
);

  step_t             step;
  logic              take;
  logic              pop;
  result_t           queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  result_t           head;

  assign src_stall = (count > QCNT_W'(QDEPTH - RES_MAX));
  assign take      = src_valid && !src_stall;
  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;

  sexp_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .source_char (source_char),
    .end_of_text (end_of_text),
    .step        (step)
  );

  // Queue occupancy
  assign count_next = count - QCNT_W'(pop) + (take ? QCNT_W'(step.n) : QCNT_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count <= count_next;
      if (take) wr_ptr <= wr_ptr + QPTR_W'(step.n);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
    end
  end

  // Write the results of a transfer in order
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < RES_MAX; i++) begin
        if (2'(i) < step.n) queue[wr_ptr + QPTR_W'(i)] <= step.res[i];
      end
    end
  end

  // Drive the result port from the queue head
  assign head         = queue[rd_ptr];
  assign is_text      = head.is_text;
  assign text_char    = head.text_char;
  assign token_done   = head.token_done;
  assign token_class  = head.token_class;
  assign token_length = head.token_length;
  assign int_value    = $signed(head.int_value);
  assign bad_integer  = head.bad_integer;
  assign bad_escape   = head.bad_escape;
  assign unterminated = head.unterminated;
  assign last         = head.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_rest_queued: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last) |=> res_valid)
    else $error("results of a byte split from its later results");

  a_kind_onehot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_text ^ token_done))
    else $error("result is neither text nor summary, or both");

endmodule

@@ tb/testbench.sv @@
// Testbench for s_expression_tokenizer_core: directed and random Lisp-style text against
// an in-bench lexer predictor, with random idling on both valid/stall channels.
// Depends on sexp_pkg (types, character codes, token classes) and the RTL core.
`timescale 1ns / 100ps

module testbench;
  import sexp_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_stall;
  logic [7:0]         source_char = 8'h00;
  logic               end_of_text = 1'b0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic               is_text;
  logic [7:0]         text_char;
  logic               token_done;
  logic [3:0]         token_class;
  logic [7:0]         token_length;
  logic signed [31:0] int_value;
  logic               bad_integer;
  logic               bad_escape;
  logic               unterminated;
  logic               last;

  s_expression_tokenizer_core DUT (.*);

  // Lexer state mirrored by the predictor
  lex_mode_t   lx_mode;
  logic [7:0]  lx_len;
  logic [31:0] lx_acc;
  logic        lx_neg;
  logic        lx_dfault;
  logic        lx_efault;

  result_t step_buf[$];
  result_t lexeme_q[$];

  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  results_seen = 0;
  int  tokens_seen  = 0;
  bit  gaps_on      = 1'b0;
  bit  stall_on     = 1'b0;
  int  stall_left   = 0;

  logic [7:0] blank_set [5]   = '{CH_SPACE, CH_NEWLINE, CH_COMMA, CH_TAB, CH_CR};
  logic [7:0] punct_set [10]  = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                                  CH_RBRACE, CH_APOS, CH_BTICK, CH_CARET, CH_TILDE};

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lexer predictor
  // ---------------------------------------------------------------------------
  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_NEWLINE || c == CH_COMMA || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic int punct_class(input logic [7:0] c);
    case (c)
      CH_LPAREN: return int'(CLS_LPAREN);
      CH_RPAREN: return int'(CLS_RPAREN);
      CH_LBRACK: return int'(CLS_LBRACK);
      CH_RBRACK: return int'(CLS_RBRACK);
      CH_LBRACE: return int'(CLS_LBRACE);
      CH_RBRACE: return int'(CLS_RBRACE);
      CH_APOS:   return int'(CLS_QUOTE);
      CH_BTICK:  return int'(CLS_QUASI);
      CH_CARET:  return int'(CLS_META);
      CH_TILDE:  return int'(CLS_TILDE);
      default:   return -1;
    endcase
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic put_char(input logic [7:0] c);
    result_t r;
    r = '0;
    r.is_text   = 1'b1;
    r.text_char = c;
    step_buf.push_back(r);
  endtask

  task automatic put_summary(input logic [3:0] cls, input logic [7:0] len,
                             input logic [31:0] val, input logic bi, input logic be,
                             input logic un);
    result_t r;
    r = '0;
    r.token_done   = 1'b1;
    r.token_class  = cls;
    r.token_length = len;
    r.int_value    = val;
    r.bad_integer  = bi;
    r.bad_escape   = be;
    r.unterminated = un;
    step_buf.push_back(r);
  endtask

  task automatic clear_token();
    lx_mode   = M_IDLE;
    lx_len    = 8'd0;
    lx_acc    = 32'd0;
    lx_neg    = 1'b0;
    lx_dfault = 1'b0;
    lx_efault = 1'b0;
  endtask

  // Count one more source character, saturating at the length cap
  task automatic grow();
    if (lx_len < LEN_CAP) lx_len = lx_len + 8'd1;
  endtask

  task automatic close_atom();
    if (lx_mode == M_INTEGER) begin
      put_summary(CLS_INT, lx_len, lx_neg ? 32'd0 - lx_acc : lx_acc, lx_dfault, 1'b0, 1'b0);
    end else begin
      put_summary(CLS_SYMBOL, lx_len, 32'd0, 1'b0, 1'b0, 1'b0);
    end
    clear_token();
  endtask

  // Lex a byte met between tokens
  task automatic start_token(input logic [7:0] c);
    int cls;
    cls = punct_class(c);
    if (blank_char(c)) begin
      lx_mode = M_IDLE;
    end else if (c == CH_SEMI) begin
      lx_mode = M_COMMENT;
    end else if (cls >= 0) begin
      put_char(c);
      if (c == CH_TILDE) begin
        lx_len  = 8'd1;
        lx_mode = M_TILDE;
      end else begin
        put_summary(4'(cls), 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      lx_len = 8'd1;
      if (c == CH_QUOTE) begin
        lx_mode = M_STRING;
      end else begin
        put_char(c);
        if (c == CH_MINUS || digit_char(c)) begin
          lx_mode = M_INTEGER;
          lx_neg  = (c == CH_MINUS);
          lx_acc  = lx_neg ? 32'd0 : 32'(c) - 32'(CH_ZERO);
        end else begin
          lx_mode = M_SYMBOL;
        end
      end
    end
  endtask

  // Close whatever token is pending at end of input or on a zero byte
  task automatic flush_token();
    case (lx_mode)
      M_TILDE:            put_summary(CLS_TILDE, 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
      M_STRING, M_ESCAPE: put_summary(CLS_STRING, lx_len, 32'd0, 1'b0, lx_efault, 1'b1);
      M_INTEGER, M_SYMBOL: close_atom();
      default: ;
    endcase
    clear_token();
  endtask

  // Work out the results of one accepted byte and queue them
  task automatic lex_byte(input logic [7:0] c, input logic eot);
    result_t r;
    step_buf.delete();
    if (eot || c == CH_NUL) begin
      flush_token();
    end else begin
      case (lx_mode)
        M_COMMENT: begin
          if (c == CH_NEWLINE) lx_mode = M_IDLE;
        end
        M_TILDE: begin
          if (c == CH_AT) begin
            put_char(c);
            put_summary(CLS_SPLICE, 8'd2, 32'd0, 1'b0, 1'b0, 1'b0);
            clear_token();
          end else begin
            put_summary(CLS_TILDE, 8'd1, 32'd0, 1'b0, 1'b0, 1'b0);
            clear_token();
            start_token(c);
          end
        end
        M_STRING: begin
          grow();
          if (c == CH_QUOTE) begin
            put_summary(CLS_STRING, lx_len, 32'd0, 1'b0, lx_efault, 1'b0);
            clear_token();
          end else if (c == CH_BSLASH) begin
            lx_mode = M_ESCAPE;
          end else begin
            put_char(c);
          end
        end
        M_ESCAPE: begin
          grow();
          if (c == CH_QUOTE || c == CH_BSLASH) put_char(c);
          else if (c == CH_N) put_char(CH_NEWLINE);
          else lx_efault = 1'b1;
          lx_mode = M_STRING;
        end
        M_INTEGER, M_SYMBOL: begin
          if (blank_char(c) || punct_class(c) >= 0) begin
            close_atom();
            start_token(c);
          end else begin
            grow();
            put_char(c);
            if (lx_mode == M_INTEGER && !lx_dfault) begin
              if (digit_char(c)) lx_acc = lx_acc * 32'd10 + 32'(c) - 32'(CH_ZERO);
              else lx_dfault = 1'b1;
            end
          end
        end
        default: begin
          lx_mode = M_IDLE;
          start_token(c);
        end
      endcase
    end
    // Mark the final result of this byte
    if (step_buf.size() > 0) begin
      r = step_buf.pop_back();
      r.last = 1'b1;
      step_buf.push_back(r);
    end
    foreach (step_buf[i]) lexeme_q.push_back(step_buf[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    @(negedge clk);
    // Insert an idle burst now and then
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid   <= 1'b1;
    source_char <= c;
    end_of_text <= eot;
    do @(posedge clk); while (src_stall);
    lex_byte(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold the source until every queued result has drained
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (lexeme_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the check of each transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!stall_on) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic void match_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (lexeme_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = lexeme_q.pop_front();
        if (want.token_done) tokens_seen++;
        match_field("is_text", 32'(want.is_text), 32'(is_text));
        match_field("text_char", 32'(want.text_char), 32'(text_char));
        match_field("token_done", 32'(want.token_done), 32'(token_done));
        match_field("token_class", 32'(want.token_class), 32'(token_class));
        match_field("token_length", 32'(want.token_length), 32'(token_length));
        match_field("int_value", want.int_value, int_value);
        match_field("bad_integer", 32'(want.bad_integer), 32'(bad_integer));
        match_field("bad_escape", 32'(want.bad_escape), 32'(bad_escape));
        match_field("unterminated", 32'(want.unterminated), 32'(unterminated));
        match_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] atom_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (blank_char(c) || punct_class(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] symbol_head();
    logic [7:0] c;
    do c = atom_byte();
    while (c == CH_QUOTE || c == CH_SEMI || c == CH_MINUS || digit_char(c));
    return c;
  endfunction

  // Close an atom by a blank, a special character, a zero byte or end of input
  task automatic send_break();
    int k;
    k = $urandom_range(0, 5);
    if (k < 3) send_char(blank_set[$urandom_range(0, 4)], 1'b0);
    else if (k < 5) send_char(punct_set[$urandom_range(0, 9)], 1'b0);
    else if ($urandom_range(0, 1)) send_end();
    else send_char(CH_NUL, 1'b0);
  endtask

  task automatic send_random_form();
    int n;
    int bad_at;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        // integer, sometimes with a stray character
        if ($urandom_range(0, 2) == 0) send_char(CH_MINUS, 1'b0);
        n = $urandom_range(1, 12);
        bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
          if (i == bad_at) send_char(atom_byte(), 1'b0);
          else send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        send_break();
      end
      2: begin
        send_char(symbol_head(), 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_char(atom_byte(), 1'b0);
        send_break();
      end
      3, 4: begin
        send_char(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_char(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 3))
              0: send_char(CH_QUOTE, 1'b0);
              1: send_char(CH_BSLASH, 1'b0);
              2: send_char(CH_N, 1'b0);
              default: send_char(8'($urandom_range(1, 255)), 1'b0);
            endcase
          end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            send_char(c, 1'b0);
          end
        end
        if ($urandom_range(0, 7) == 0) send_end();
        else send_char(CH_QUOTE, 1'b0);
      end
      5: begin
        c = punct_set[$urandom_range(0, 9)];
        send_char(c, 1'b0);
        if (c == CH_TILDE && $urandom_range(0, 1)) send_char(CH_AT, 1'b0);
      end
      6: begin
        send_char(CH_SEMI, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_NEWLINE);
          send_char(c, 1'b0);
        end
        if ($urandom_range(0, 5) == 0) send_end();
        else send_char(CH_NEWLINE, 1'b0);
      end
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) send_char(blank_set[$urandom_range(0, 4)], 1'b0);
      end
      8: begin
        // raw noise, any byte
        n = $urandom_range(1, 3);
        repeat (n) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
      end
      default: send_end();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_punctuation();
    // every special, splice, tilde followed by a bracket, tilde at end of input
    send_text("()[]{}'`^~@~(");
    send_char(CH_TILDE, 1'b0);
    send_end();
  endtask

  task automatic test_strings();
    // empty string, then every escape kind, an unknown escape and a missing close
    send_text("\"\"");
    send_text("\"\\\"\\\\\\n\\qx");
    send_end();
  endtask

  task automatic test_numbers_and_ends();
    // lone minus, minus then letter with a semicolon inside, close by a bracket
    send_text("-,-x;1(7");
    // zero byte closes the integer, end of input in idle and in a comment
    send_char(CH_NUL, 1'b0);
    send_char(8'hA5, 1'b1);
    send_text(";c");
    send_char(8'h5A, 1'b1);
    // top byte value starts a symbol that swallows a quote and a semicolon
    send_char(8'hFF, 1'b0);
    send_text("\";");
    send_char(CH_NUL, 1'b1);
  endtask

  task automatic test_long_tokens();
    // wraparound of the accumulator both ways
    send_text("4294967296 -2147483649 99999999999 ");
  endtask

  task automatic test_random_text();
    int start;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent < start + 30) begin
      send_random_form();
      if (!paused && bytes_sent >= start + 15) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_steady_stream();
    int start;
    start = bytes_sent;
    while (bytes_sent < start + 12) send_random_form();
    send_end();
  endtask

  initial begin
    clear_token();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_punctuation();
    test_strings();
    test_numbers_and_ends();
    test_long_tokens();
    test_random_text();

    // no idling on either side for the tail of the run
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_steady_stream();

    @(negedge clk);
    src_valid <= 1'b0;
    while (lexeme_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Lexed %0d source bytes into %0d results, %0d of them token summaries.",
             bytes_sent, results_seen, tokens_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #5000000;
    $display("Timeout with %0d results still expected", lexeme_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
